>>> rtl/atcr_pkg.sv
// shared types, character codes and helper functions for the at command recognizer
package atcr_pkg;

   localparam int NAME_MAX_DEF = 16;
   localparam int ARGS_MAX_DEF = 64;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] TIMER_SAT     = 16'hFFFF;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_T = 8'h54;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [2:0] EV_NAME    = 3'd0;
   localparam logic [2:0] EV_ARG     = 3'd1;
   localparam logic [2:0] EV_DONE    = 3'd2;
   localparam logic [2:0] EV_ERR     = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;

   localparam logic [1:0] KIND_EXEC = 2'd0;
   localparam logic [1:0] KIND_GET  = 2'd1;
   localparam logic [1:0] KIND_TEST = 2'd2;
   localparam logic [1:0] KIND_SET  = 2'd3;

   localparam logic ERR_POS   = 1'b0;
   localparam logic ERR_PARAM = 1'b1;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_GOT_A = 6'b000010,
      PH_PLUS  = 6'b000100,
      PH_NAME  = 6'b001000,
      PH_OPER  = 6'b010000,
      PH_END   = 6'b100000
   } atcr_phase_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] out_char;
      logic [1:0] command_kind;
      logic       error_kind;
      logic [4:0] name_length;
      logic [6:0] arg_length;
   } atcr_rsp_type;

   typedef struct packed {
      logic         valid;
      atcr_rsp_type payload;
   } atcr_result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_arg_char(input logic [7:0] c);
      return is_letter(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
             (c == CH_QUOTE) || (c == CH_MINUS) || (c == CH_DOT) ||
             (c == CH_COLON) || (c == CH_COMMA);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

>>> rtl/atcr_if.sv
// valid/ready channel interfaces for received bytes and recognizer events
interface atcr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source(output valid, output mode, output data_byte, input ready);
   modport sink(input valid, input mode, input data_byte, output ready);
endinterface

interface atcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] out_char;
   logic [1:0] command_kind;
   logic       error_kind;
   logic [4:0] name_length;
   logic [6:0] arg_length;

   modport source(output valid, output event_res, output out_char, output command_kind,
                  output error_kind, output name_length, output arg_length, input ready);
   modport sink(input valid, input event_res, input out_char, input command_kind,
                input error_kind, input name_length, input arg_length, output ready);
endinterface

>>> rtl/atcr_core.sv
// parse state, timeout timer and per-transaction event decode
module atcr_core #(
   parameter int NAME_MAX = atcr_pkg::NAME_MAX_DEF,
   parameter int ARGS_MAX = atcr_pkg::ARGS_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic                      mode,
   input  logic [7:0]                data_byte,
   input  logic [15:0]               timeout_ticks,
   output atcr_pkg::atcr_result_type result
);

   localparam int NameCountWidth = $clog2(NAME_MAX + 1);
   localparam int ArgCountWidth  = $clog2(ARGS_MAX + 1);

   atcr_pkg::atcr_phase_type  phase_ff, phase_in;
   logic [NameCountWidth-1:0] name_cnt_ff, name_cnt_in;
   logic [ArgCountWidth-1:0]  arg_cnt_ff, arg_cnt_in;
   logic [1:0]                kind_ff, kind_in;
   logic                      timer_run_ff, timer_run_in;
   logic [15:0]               timer_cnt_ff, timer_cnt_in;
   logic [15:0]               timer_next;
   logic                      do_clear;
   logic                      name_some;
   logic                      arg_some;

   assign name_some = (name_cnt_ff != '0);
   assign arg_some  = (arg_cnt_ff != '0);
   assign timer_next = (timer_cnt_ff != atcr_pkg::TIMER_SAT) ?
                       (timer_cnt_ff + 16'd1) : timer_cnt_ff;

   always_comb begin
      phase_in     = phase_ff;
      name_cnt_in  = name_cnt_ff;
      arg_cnt_in   = arg_cnt_ff;
      kind_in      = kind_ff;
      timer_run_in = timer_run_ff;
      timer_cnt_in = timer_cnt_ff;
      do_clear     = 1'b0;
      result       = '0;

      if (fire) begin
         if (mode == atcr_pkg::MODE_TICK) begin
            if (timer_run_ff) begin
               timer_cnt_in = timer_next;
               if (timer_next >= timeout_ticks) begin
                  do_clear = 1'b1;
                  result.valid = 1'b1;
                  result.payload.event_res = atcr_pkg::EV_TIMEOUT;
               end
            end
         end else begin
            unique case (phase_ff)
               atcr_pkg::PH_IDLE: begin
                  if ((data_byte == atcr_pkg::CH_UPPER_A) ||
                      (data_byte == atcr_pkg::CH_LOWER_A)) begin
                     phase_in    = atcr_pkg::PH_GOT_A;
                     name_cnt_in = '0;
                     arg_cnt_in  = '0;
                  end
               end
               atcr_pkg::PH_GOT_A: begin
                  if ((data_byte == atcr_pkg::CH_UPPER_T) ||
                      (data_byte == atcr_pkg::CH_LOWER_T)) begin
                     phase_in     = atcr_pkg::PH_PLUS;
                     timer_run_in = 1'b1;
                     timer_cnt_in = '0;
                  end else begin
                     phase_in = atcr_pkg::PH_IDLE;
                  end
               end
               atcr_pkg::PH_PLUS: begin
                  if (data_byte == atcr_pkg::CH_PLUS) begin
                     phase_in = atcr_pkg::PH_NAME;
                  end else if (data_byte == atcr_pkg::CH_CR) begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res    = atcr_pkg::EV_DONE;
                     result.payload.command_kind = atcr_pkg::KIND_EXEC;
                     result.payload.name_length  = 5'(name_cnt_ff);
                     result.payload.arg_length   = 7'(arg_cnt_ff);
                  end else begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res  = atcr_pkg::EV_ERR;
                     result.payload.error_kind = atcr_pkg::ERR_POS;
                  end
               end
               atcr_pkg::PH_NAME: begin
                  if ((data_byte == atcr_pkg::CH_QUERY) && name_some) begin
                     kind_in  = atcr_pkg::KIND_GET;
                     phase_in = atcr_pkg::PH_END;
                  end else if ((data_byte == atcr_pkg::CH_EQUAL) && name_some) begin
                     phase_in = atcr_pkg::PH_OPER;
                  end else if ((data_byte == atcr_pkg::CH_CR) && name_some) begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res    = atcr_pkg::EV_DONE;
                     result.payload.command_kind = atcr_pkg::KIND_EXEC;
                     result.payload.name_length  = 5'(name_cnt_ff);
                     result.payload.arg_length   = 7'(arg_cnt_ff);
                  end else if (atcr_pkg::is_letter(data_byte) &&
                               (name_cnt_ff < NameCountWidth'(NAME_MAX))) begin
                     name_cnt_in = name_cnt_ff + NameCountWidth'(1);
                     result.valid = 1'b1;
                     result.payload.event_res = atcr_pkg::EV_NAME;
                     result.payload.out_char  = atcr_pkg::to_upper(data_byte);
                  end else begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res  = atcr_pkg::EV_ERR;
                     result.payload.error_kind = atcr_pkg::ERR_POS;
                  end
               end
               atcr_pkg::PH_OPER: begin
                  if ((data_byte == atcr_pkg::CH_QUERY) && !arg_some) begin
                     kind_in  = atcr_pkg::KIND_TEST;
                     phase_in = atcr_pkg::PH_END;
                  end else if ((data_byte == atcr_pkg::CH_CR) && arg_some) begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res    = atcr_pkg::EV_DONE;
                     result.payload.command_kind = atcr_pkg::KIND_SET;
                     result.payload.name_length  = 5'(name_cnt_ff);
                     result.payload.arg_length   = 7'(arg_cnt_ff);
                  end else if (atcr_pkg::is_arg_char(data_byte) &&
                               (arg_cnt_ff < ArgCountWidth'(ARGS_MAX))) begin
                     kind_in    = atcr_pkg::KIND_SET;
                     arg_cnt_in = arg_cnt_ff + ArgCountWidth'(1);
                     result.valid = 1'b1;
                     result.payload.event_res = atcr_pkg::EV_ARG;
                     result.payload.out_char  = data_byte;
                  end else begin
                     do_clear = 1'b1;
                     result.valid = 1'b1;
                     result.payload.event_res  = atcr_pkg::EV_ERR;
                     result.payload.error_kind = atcr_pkg::ERR_PARAM;
                  end
               end
               atcr_pkg::PH_END: begin
                  do_clear = 1'b1;
                  result.valid = 1'b1;
                  if (data_byte == atcr_pkg::CH_CR) begin
                     result.payload.event_res    = atcr_pkg::EV_DONE;
                     result.payload.command_kind = kind_ff;
                     result.payload.name_length  = 5'(name_cnt_ff);
                     result.payload.arg_length   = 7'(arg_cnt_ff);
                  end else begin
                     result.payload.event_res  = atcr_pkg::EV_ERR;
                     result.payload.error_kind = atcr_pkg::ERR_POS;
                  end
               end
               default: begin
                  do_clear = 1'b1;
               end
            endcase
         end
      end

      if (do_clear) begin
         phase_in     = atcr_pkg::PH_IDLE;
         name_cnt_in  = '0;
         arg_cnt_in   = '0;
         kind_in      = atcr_pkg::KIND_EXEC;
         timer_run_in = 1'b0;
         timer_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= atcr_pkg::PH_IDLE;
         name_cnt_ff  <= '0;
         arg_cnt_ff   <= '0;
         kind_ff      <= atcr_pkg::KIND_EXEC;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         name_cnt_ff  <= name_cnt_in;
         arg_cnt_ff   <= arg_cnt_in;
         kind_ff      <= kind_in;
         timer_run_ff <= timer_run_in;
         timer_cnt_ff <= timer_cnt_in;
      end
   end

   // timer only runs once the full AT prefix has been seen
   a_timer_after_at: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == atcr_pkg::PH_IDLE) || (phase_ff == atcr_pkg::PH_GOT_A)) |-> !timer_run_ff)
      else $error("timer running before AT prefix");

   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      name_cnt_ff <= NameCountWidth'(NAME_MAX))
      else $error("name count above limit");

   a_arg_bound: assert property (@(posedge clock) disable iff (reset)
      arg_cnt_ff <= ArgCountWidth'(ARGS_MAX))
      else $error("argument count above limit");

   // any terminal event drops the parse back to idle with counts cleared
   a_terminal_clears: assert property (@(posedge clock) disable iff (reset)
      (result.valid && ((result.payload.event_res == atcr_pkg::EV_DONE) ||
                        (result.payload.event_res == atcr_pkg::EV_ERR) ||
                        (result.payload.event_res == atcr_pkg::EV_TIMEOUT)))
      |=> ((phase_ff == atcr_pkg::PH_IDLE) && (name_cnt_ff == '0) && (arg_cnt_ff == '0)))
      else $error("parse state not cleared after terminal event");

   a_arg_only_in_oper: assert property (@(posedge clock) disable iff (reset)
      arg_some |-> ((phase_ff == atcr_pkg::PH_OPER) || (phase_ff == atcr_pkg::PH_END)))
      else $error("argument count held outside argument phase");

endmodule

>>> rtl/at_command_recognizer.sv
// at command recognizer top level: input register, parse core, result register
// throughput: one transaction per cycle while the result register is not stalled, set by the single-pass parse stage
// the input register drains whenever the result register is empty or being read
// reset clears the parse state, the timer and both pipeline valids and loads
// the timeout register with 1000 ticks
module at_command_recognizer #(
   parameter int NAME_MAX = atcr_pkg::NAME_MAX_DEF,
   parameter int ARGS_MAX = atcr_pkg::ARGS_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   atcr_req_if.sink    req_bus,
   atcr_rsp_if.source  rsp_bus,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic                      in_valid_ff, in_valid_in;
   logic                      in_mode_ff;
   logic [7:0]                in_byte_ff;
   logic                      out_valid_ff, out_valid_in;
   atcr_pkg::atcr_rsp_type    out_ff;
   logic [15:0]               timeout_ff;
   logic                      stall;
   logic                      parse_fire;
   logic                      req_fire;
   atcr_pkg::atcr_result_type result;

   assign stall      = out_valid_ff && !rsp_bus.ready;
   assign parse_fire = in_valid_ff && !stall;
   assign req_bus.ready = !in_valid_ff || !stall;
   assign req_fire   = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (parse_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (parse_fire && result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   atcr_core #(
      .NAME_MAX(NAME_MAX),
      .ARGS_MAX(ARGS_MAX)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .fire(parse_fire),
      .mode(in_mode_ff),
      .data_byte(in_byte_ff),
      .timeout_ticks(timeout_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= atcr_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff <= req_bus.mode;
         in_byte_ff <= req_bus.data_byte;
      end
      if (parse_fire && result.valid) begin
         out_ff <= result.payload;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.event_res    = out_ff.event_res;
   assign rsp_bus.out_char     = out_ff.out_char;
   assign rsp_bus.command_kind = out_ff.command_kind;
   assign rsp_bus.error_kind   = out_ff.error_kind;
   assign rsp_bus.name_length  = out_ff.name_length;
   assign rsp_bus.arg_length   = out_ff.arg_length;

endmodule

>>> bench/atcr_event_checker.sv
// transaction monitor, event predictor and result checker for the at command recognizer
module atcr_event_checker
   import atcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   atcr_req_if         req_mon,
   atcr_rsp_if         rsp_mon,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output int          mismatch_count,
   output int          events_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NAME_LIMIT = NAME_MAX_DEF;
   localparam int ARGS_LIMIT = ARGS_MAX_DEF;

   logic [15:0]    timeout_limit;
   atcr_phase_type cmd_phase;
   logic [4:0]     name_chars;
   logic [6:0]     arg_chars;
   logic [1:0]     held_kind;
   logic           timer_on;
   logic [15:0]    tick_count;
   atcr_rsp_type   expected_events[$];

   function automatic logic letter_char(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic argument_char(input logic [7:0] c);
      return letter_char(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
             (c == CH_QUOTE) || (c == CH_MINUS) || (c == CH_DOT) ||
             (c == CH_COLON) || (c == CH_COMMA);
   endfunction

   function automatic void clear_command();
      cmd_phase   = PH_IDLE;
      name_chars  = '0;
      arg_chars   = '0;
      held_kind   = KIND_EXEC;
      timer_on    = 1'b0;
      tick_count  = '0;
   endfunction

   function automatic atcr_rsp_type finish_command(input logic [1:0] kind);
      atcr_rsp_type ev;
      ev = '0;
      ev.event_res    = EV_DONE;
      ev.command_kind = kind;
      ev.name_length  = name_chars;
      ev.arg_length   = arg_chars;
      clear_command();
      return ev;
   endfunction

   function automatic atcr_rsp_type reject_command(input logic err);
      atcr_rsp_type ev;
      ev = '0;
      ev.event_res  = EV_ERR;
      ev.error_kind = err;
      clear_command();
      return ev;
   endfunction

   function automatic logic step_parser(input logic mode, input logic [7:0] c,
                                        output atcr_rsp_type ev);
      logic produced;
      ev = '0;
      produced = 1'b0;
      if (mode == MODE_TICK) begin
         if (timer_on) begin
            if (tick_count != TIMER_SAT) begin
               tick_count = tick_count + 16'd1;
            end
            if (tick_count >= timeout_limit) begin
               clear_command();
               ev.event_res = EV_TIMEOUT;
               produced = 1'b1;
            end
         end
         return produced;
      end
      produced = 1'b1;
      case (cmd_phase)
         PH_IDLE: begin
            produced = 1'b0;
            if ((c == CH_UPPER_A) || (c == CH_LOWER_A)) begin
               cmd_phase  = PH_GOT_A;
               name_chars = '0;
               arg_chars  = '0;
            end
         end
         PH_GOT_A: begin
            produced = 1'b0;
            if ((c == CH_UPPER_T) || (c == CH_LOWER_T)) begin
               cmd_phase  = PH_PLUS;
               timer_on   = 1'b1;
               tick_count = '0;
            end else begin
               cmd_phase = PH_IDLE;
            end
         end
         PH_PLUS: begin
            if (c == CH_PLUS) begin
               cmd_phase = PH_NAME;
               produced = 1'b0;
            end else if (c == CH_CR) begin
               ev = finish_command(KIND_EXEC);
            end else begin
               ev = reject_command(ERR_POS);
            end
         end
         PH_NAME: begin
            if ((c == CH_QUERY) && (name_chars != 0)) begin
               held_kind = KIND_GET;
               cmd_phase = PH_END;
               produced = 1'b0;
            end else if ((c == CH_EQUAL) && (name_chars != 0)) begin
               cmd_phase = PH_OPER;
               produced = 1'b0;
            end else if ((c == CH_CR) && (name_chars != 0)) begin
               ev = finish_command(KIND_EXEC);
            end else if (!letter_char(c) || (name_chars >= NAME_LIMIT)) begin
               ev = reject_command(ERR_POS);
            end else begin
               name_chars   = name_chars + 5'd1;
               ev.event_res = EV_NAME;
               ev.out_char  = (c >= CH_LOWER_A) ? c - CASE_DELTA : c;
            end
         end
         PH_OPER: begin
            if ((c == CH_QUERY) && (arg_chars == 0)) begin
               held_kind = KIND_TEST;
               cmd_phase = PH_END;
               produced = 1'b0;
            end else if ((c == CH_CR) && (arg_chars != 0)) begin
               ev = finish_command(KIND_SET);
            end else if (!argument_char(c) || (arg_chars >= ARGS_LIMIT)) begin
               ev = reject_command(ERR_PARAM);
            end else begin
               held_kind    = KIND_SET;
               arg_chars    = arg_chars + 7'd1;
               ev.event_res = EV_ARG;
               ev.out_char  = c;
            end
         end
         PH_END: begin
            if (c == CH_CR) begin
               ev = finish_command(held_kind);
            end else begin
               ev = reject_command(ERR_POS);
            end
         end
         default: begin
            clear_command();
            produced = 1'b0;
         end
      endcase
      return produced;
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      atcr_rsp_type predicted;
      atcr_rsp_type oldest;
      if (reset) begin
         timeout_limit = TIMEOUT_RESET;
         clear_command();
         expected_events.delete();
      end else begin
         if (csr_write_enable) begin
            timeout_limit = csr_write_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (step_parser(req_mon.mode, req_mon.data_byte, predicted)) begin
               expected_events.push_back(predicted);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected transaction: event_res %0d", rsp_mon.event_res);
               mismatch_count++;
            end else begin
               oldest = expected_events.pop_front();
               check_field("event_res", oldest.event_res, rsp_mon.event_res);
               check_field("out_char", oldest.out_char, rsp_mon.out_char);
               check_field("command_kind", oldest.command_kind, rsp_mon.command_kind);
               check_field("error_kind", oldest.error_kind, rsp_mon.error_kind);
               check_field("name_length", oldest.name_length, rsp_mon.name_length);
               check_field("arg_length", oldest.arg_length, rsp_mon.arg_length);
            end
         end
      end
      events_waiting = expected_events.size();
   end

endmodule

>>> bench/tb_at_command_recognizer.sv
// stimulus, clock, reset and verdict for the at command recognizer testbench
module tb_at_command_recognizer;
   timeunit 1ns;
   timeprecision 1ps;
   import atcr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 320;
   localparam int PHASE_TIMEOUT[4] = '{8, 65535, 3, 1};
   localparam int PHASE_SENDER_IDLE[4] = '{0, 52, 0, 23};
   localparam int PHASE_RECEIVER_STALL[4] = '{0, 0, 52, 23};
   localparam int PHASE_TICK_PCT[4] = '{4, 3, 6, 2};

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   int          mismatch_count;
   int          events_waiting;
   int          items_sent;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          tick_pct;
   int          cycle_count;

   atcr_req_if req_bus();
   atcr_rsp_if rsp_bus();

   at_command_recognizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   atcr_event_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .events_waiting   (events_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic send_item(input logic mode, input logic [7:0] b);
      @(negedge clock);
      while ((sender_idle_pct != 0) && ($urandom_range(0, 99) < sender_idle_pct)) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_tick();
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      send_item(MODE_TICK, junk);
   endtask

   task automatic send_char(input logic [7:0] c);
      if ($urandom_range(0, 99) < tick_pct) begin
         send_tick();
      end
      send_item(MODE_BYTE, c);
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (events_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] ticks);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] random_case(input logic [7:0] up);
      return $urandom_range(0, 1) ? up : up + CASE_DELTA;
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] up;
      up = CH_UPPER_A + 8'($urandom_range(0, 25));
      return random_case(up);
   endfunction

   function automatic logic [7:0] random_arg_char();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: c = random_letter();
         4, 5:       c = CH_DIGIT_0 + 8'($urandom_range(0, 9));
         6:          c = CH_QUOTE;
         7:          c = CH_MINUS;
         8:          c = CH_DOT;
         default:    c = $urandom_range(0, 1) ? CH_COLON : CH_COMMA;
      endcase
      return c;
   endfunction

   task automatic send_name(input int count);
      repeat (count) send_char(random_letter());
   endtask

   task automatic send_args(input int count);
      repeat (count) send_char(random_arg_char());
   endtask

   task automatic send_command();
      int         shape;
      int         name_len;
      logic [7:0] junk;
      shape = $urandom_range(0, 19);
      junk  = 8'($urandom_range(0, 255));
      if (shape == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_char(junk);
            junk = 8'($urandom_range(0, 255));
         end
         return;
      end
      send_char(random_case(CH_UPPER_A));
      if (shape == 1) begin
         send_char(junk);
         return;
      end
      send_char(random_case(CH_UPPER_T));
      if (shape == 2) begin
         send_char(CH_CR);
         return;
      end
      if (shape == 3) begin
         send_char(junk);
         send_char(CH_CR);
         return;
      end
      send_char(CH_PLUS);
      if (shape == 4) begin
         name_len = $urandom_range(0, 1) ? NAME_MAX_DEF : NAME_MAX_DEF + 1;
      end else if (shape == 17) begin
         name_len = $urandom_range(0, 3);
      end else begin
         name_len = $urandom_range(1, 6);
      end
      send_name(name_len);
      case (shape)
         7, 8: begin
            send_char(CH_QUERY);
            send_char(CH_CR);
         end
         9, 10: begin
            send_char(CH_EQUAL);
            send_char(CH_QUERY);
            send_char(CH_CR);
         end
         11, 12, 13, 14, 15: begin
            send_char(CH_EQUAL);
            send_args($urandom_range(1, 8));
            send_char(CH_CR);
         end
         16: begin
            send_char(CH_EQUAL);
            send_args($urandom_range(0, 1) ? ARGS_MAX_DEF : ARGS_MAX_DEF + 1);
            send_char(CH_CR);
         end
         17: begin
            send_char(junk);
            send_char(CH_CR);
         end
         18: begin
            send_char(CH_EQUAL);
            if ($urandom_range(0, 1)) begin
               send_args($urandom_range(1, 4));
               send_char(CH_QUERY);
            end else if ($urandom_range(0, 1)) begin
               send_args($urandom_range(0, 3));
               send_char(junk);
            end
            send_char(CH_CR);
         end
         19: begin
            if ($urandom_range(0, 1)) begin
               send_char(CH_QUERY);
            end else begin
               send_char(CH_EQUAL);
               send_char(CH_QUERY);
            end
            send_char(junk);
         end
         default: send_char(CH_CR);
      endcase
   endtask

   initial begin
      int start_count;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_BYTE;
      req_bus.data_byte  = '0;
      items_sent         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      tick_pct           = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ignored input, bad second letter, execute, test, empty set, timeouts
      send_tick();
      send_item(MODE_BYTE, 8'hFF);
      send_item(MODE_BYTE, CH_UPPER_A);
      send_item(MODE_BYTE, CH_UPPER_A + 8'd1);
      send_item(MODE_BYTE, CH_LOWER_A);
      send_item(MODE_BYTE, CH_UPPER_T);
      send_item(MODE_BYTE, CH_CR);
      send_item(MODE_BYTE, CH_UPPER_A);
      send_item(MODE_BYTE, CH_LOWER_T);
      send_item(MODE_BYTE, CH_PLUS);
      send_item(MODE_BYTE, CH_LOWER_Z);
      send_item(MODE_BYTE, CH_EQUAL);
      send_item(MODE_BYTE, CH_QUERY);
      send_item(MODE_BYTE, CH_CR);
      send_item(MODE_BYTE, CH_UPPER_A);
      send_item(MODE_BYTE, CH_UPPER_T);
      send_item(MODE_BYTE, CH_PLUS);
      send_item(MODE_BYTE, CH_LOWER_A + 8'd12);
      send_item(MODE_BYTE, CH_EQUAL);
      send_item(MODE_BYTE, CH_CR);
      send_item(MODE_BYTE, CH_UPPER_A);
      send_item(MODE_BYTE, CH_UPPER_T);
      send_tick();
      send_tick();
      set_timeout(16'hFFFF);
      send_tick();
      set_timeout(16'd2);
      send_tick();
      set_timeout(16'd0);
      send_item(MODE_BYTE, CH_UPPER_A);
      send_item(MODE_BYTE, CH_UPPER_T);
      send_tick();

      for (int p = 0; p < 4; p++) begin
         set_timeout(16'(PHASE_TIMEOUT[p]));
         sender_idle_pct    = PHASE_SENDER_IDLE[p];
         receiver_stall_pct = PHASE_RECEIVER_STALL[p];
         tick_pct           = PHASE_TICK_PCT[p];
         start_count        = items_sent;
         while (items_sent - start_count < PHASE_ITEMS) send_command();
      end

      drain();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
